// ----- src/mif_pkg.sv -----
// shared types, widths and helpers for the pointer inertia filter
package mif_pkg;

    localparam int MUL_A_W  = 48;
    localparam int MUL_B_W  = 16;
    localparam int MUL_P_W  = 64;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    localparam int SQ_IN_W  = 50;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_OUT_W + 2;
    localparam int SQ_CNT_W = $clog2(SQ_OUT_W);

    localparam int DIV_N_W   = 38;
    localparam int DIV_D_W   = 25;
    localparam int DIV_Q_W   = 15;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [15:0] SPEED_FACTOR_RST = 16'd256;
    localparam logic [15:0] DECEL_RST        = 16'd256;

    localparam logic CFG_SPEED_FACTOR = 1'b0;
    localparam logic CFG_DECELERATION = 1'b1;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_MUL_AX   = 13'b0000000000010,
        S_MUL_AY   = 13'b0000000000100,
        S_SQRT     = 13'b0000000001000,
        S_DIV_X    = 13'b0000000010000,
        S_DIV_Y    = 13'b0000000100000,
        S_MUL_CAND = 13'b0000001000000,
        S_MUL_LOSS = 13'b0000010000000,
        S_MUL_MX   = 13'b0000100000000,
        S_MUL_DX   = 13'b0001000000000,
        S_MUL_MY   = 13'b0010000000000,
        S_MUL_DY   = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    // signed saturation of a magnitude to a 32-bit two's complement value
    function automatic logic [31:0] sat_out(input logic neg, input logic [47:0] mag);
        logic [31:0] res;
        if (!neg) begin
            if (mag > 48'h0000_7FFF_FFFF) res = 32'h7FFF_FFFF;
            else res = mag[31:0];
        end else begin
            if (mag > 48'h0000_8000_0000) res = 32'h8000_0000;
            else res = 32'h0 - mag[31:0];
        end
        return res;
    endfunction

endpackage

// ----- src/mif_mul.sv -----
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
module mif_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mif_pkg::MUL_A_W-1:0]   i_a,
    input  logic [mif_pkg::MUL_B_W-1:0]   i_b,
    output logic [mif_pkg::MUL_P_W-1:0]   o_p,
    output logic                          o_done
);
    logic [mif_pkg::MUL_P_W-1:0]   r_acc;
    logic [mif_pkg::MUL_P_W-1:0]   r_a;
    logic [mif_pkg::MUL_B_W-1:0]   r_b;
    logic [mif_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == mif_pkg::MUL_CNT_W'(mif_pkg::MUL_B_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= mif_pkg::MUL_P_W'(i_a);
            r_b   <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_a;
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_p    = r_acc;
    assign o_done = r_done;
endmodule

// ----- src/mif_sqrt.sv -----
// digit-serial integer square root, one result bit per cycle
module mif_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mif_pkg::SQ_IN_W-1:0]   i_n,
    output logic [mif_pkg::SQ_OUT_W-1:0]  o_root,
    output logic                          o_done
);
    logic [mif_pkg::SQ_IN_W-1:0]  r_n;
    logic [mif_pkg::SQ_REM_W-1:0] r_rem;
    logic [mif_pkg::SQ_OUT_W-1:0] r_root;
    logic [mif_pkg::SQ_CNT_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [mif_pkg::SQ_REM_W+1:0] w_part;
    logic [mif_pkg::SQ_REM_W+1:0] w_trial;
    logic                         w_ge;

    assign w_part  = {r_rem, r_n[mif_pkg::SQ_IN_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_part >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == mif_pkg::SQ_CNT_W'(mif_pkg::SQ_OUT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_n <= r_n << 2;
            if (w_ge) begin
                r_rem  <= mif_pkg::SQ_REM_W'(w_part - w_trial);
                r_root <= {r_root[mif_pkg::SQ_OUT_W-2:0], 1'b1};
            end else begin
                r_rem  <= mif_pkg::SQ_REM_W'(w_part);
                r_root <= {r_root[mif_pkg::SQ_OUT_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

// ----- src/mif_div.sv -----
// restoring divider, one quotient bit per cycle
module mif_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mif_pkg::DIV_N_W-1:0]   i_n,
    input  logic [mif_pkg::DIV_D_W-1:0]   i_d,
    output logic [mif_pkg::DIV_Q_W-1:0]   o_q,
    output logic                          o_done
);
    logic [mif_pkg::DIV_N_W-1:0]   r_n;
    logic [mif_pkg::DIV_D_W-1:0]   r_d;
    logic [mif_pkg::DIV_D_W-1:0]   r_rem;
    logic [mif_pkg::DIV_Q_W-1:0]   r_q;
    logic [mif_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [mif_pkg::DIV_D_W:0]     w_part;
    logic                          w_ge;

    assign w_part = {r_rem, r_n[mif_pkg::DIV_N_W-1]};
    assign w_ge   = (w_part >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == mif_pkg::DIV_CNT_W'(mif_pkg::DIV_N_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_d   <= i_d;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_n <= r_n << 1;
            if (w_ge) r_rem <= mif_pkg::DIV_D_W'(w_part - {1'b0, r_d});
            else r_rem <= mif_pkg::DIV_D_W'(w_part);
            r_q   <= {r_q[mif_pkg::DIV_Q_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;
endmodule

// ----- src/mouse_inertia_filter.sv -----
// top level of the pointer inertia filter: sequencer, state and output register
// Pointer inertia filter. Each transfer brings a position and a time step; the
// first one after reset only records the position and returns zero movement,
// with the result passed from the hand-over step to the output register. A
// moving item uses seven products on a shared bit-serial multiplier (two
// squares, the speed candidate and four output products), a bit-serial square
// root and two restoring divisions for the unit direction. A still item uses
// the speed loss and two output product pairs on the multiplier. One item is
// in work at a time; the input is ready again once the result sits in the
// output register, so the next item is taken while the previous result still
// waits. Configuration writes apply at once and are meant to happen while the
// block is idle.
module mouse_inertia_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic        [15:0] i_time_step,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_move_x,
    output logic signed [31:0] o_move_y,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic        [15:0] i_cfg_data
);
    mif_pkg::t_state r_state;
    logic            r_launch;

    // configuration
    logic [15:0] r_speed_factor;
    logic [15:0] r_decel;

    // filter state
    logic signed [15:0] r_last_x;
    logic signed [15:0] r_last_y;
    logic               r_primed;
    logic signed [15:0] r_dir_x;
    logic signed [15:0] r_dir_y;
    logic [31:0]        r_speed;

    // per item working registers
    logic [15:0] r_ax;
    logic [15:0] r_ay;
    logic        r_negx;
    logic        r_negy;
    logic [15:0] r_dt;
    logic        r_moving;
    logic [32:0] r_sq;
    logic [mif_pkg::SQ_OUT_W-1:0] r_len;
    logic [47:0] r_prod;
    logic [31:0] r_res_x;
    logic [31:0] r_res_y;

    // output register
    logic        r_out_valid;
    logic [31:0] r_move_x;
    logic [31:0] r_move_y;

    logic w_accept;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;

    logic [mif_pkg::MUL_A_W-1:0] w_mul_a;
    logic [mif_pkg::MUL_B_W-1:0] w_mul_b;
    logic [mif_pkg::MUL_P_W-1:0] w_mul_p;
    logic                        w_mul_done;
    logic                        w_mul_start;
    logic [mif_pkg::SQ_OUT_W-1:0] w_root;
    logic                         w_sq_done;
    logic                         w_sq_start;
    logic [mif_pkg::DIV_N_W-1:0]  w_div_n;
    logic [mif_pkg::DIV_Q_W-1:0]  w_div_q;
    logic                         w_div_done;
    logic                         w_div_start;

    logic [15:0] w_dirmag_x;
    logic [15:0] w_dirmag_y;
    logic [32:0] w_cand;
    logic [31:0] w_cand_sat;
    logic [15:0] w_loss;
    logic [31:0] w_still_speed;
    logic [31:0] w_still_lim;
    logic [47:0] w_shifted;
    logic [15:0] w_q16;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == mif_pkg::S_IDLE);

    assign w_dx = 17'(r_last_x) - 17'(i_pos_x);
    assign w_dy = 17'(r_last_y) - 17'(i_pos_y);

    assign w_dirmag_x = r_dir_x[15] ? 16'(-r_dir_x) : r_dir_x;
    assign w_dirmag_y = r_dir_y[15] ? 16'(-r_dir_y) : r_dir_y;

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            mif_pkg::S_MUL_AX: begin
                w_mul_a = 48'(r_ax);
                w_mul_b = r_ax;
            end
            mif_pkg::S_MUL_AY: begin
                w_mul_a = 48'(r_ay);
                w_mul_b = r_ay;
            end
            mif_pkg::S_MUL_CAND: begin
                w_mul_a = 48'(r_len);
                w_mul_b = r_speed_factor;
            end
            mif_pkg::S_MUL_LOSS: begin
                w_mul_a = 48'(r_decel);
                w_mul_b = r_dt;
            end
            mif_pkg::S_MUL_MX: begin
                w_mul_a = 48'(r_speed);
                w_mul_b = r_moving ? r_ax : w_dirmag_x;
            end
            mif_pkg::S_MUL_MY: begin
                w_mul_a = 48'(r_speed);
                w_mul_b = r_moving ? r_ay : w_dirmag_y;
            end
            mif_pkg::S_MUL_DX, mif_pkg::S_MUL_DY: begin
                w_mul_a = r_prod;
                w_mul_b = r_dt;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_sq_start  = r_launch && (r_state == mif_pkg::S_SQRT);
    assign w_div_start = r_launch && (r_state == mif_pkg::S_DIV_X || r_state == mif_pkg::S_DIV_Y);
    assign w_mul_start = r_launch && !w_sq_start && !w_div_start;
    assign w_div_n     = (r_state == mif_pkg::S_DIV_Y) ? {r_ay, 22'b0} : {r_ax, 22'b0};

    mif_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_p     (w_mul_p),
        .o_done  (w_mul_done)
    );

    mif_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_n     ({1'b0, r_sq, 16'b0}),
        .o_root  (w_root),
        .o_done  (w_sq_done)
    );

    mif_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n     (w_div_n),
        .i_d     (r_len),
        .o_q     (w_div_q),
        .o_done  (w_div_done)
    );

    // speed candidate while moving, saturated to 32 bits
    assign w_cand     = w_mul_p[40:8];
    assign w_cand_sat = w_cand[32] ? 32'hFFFF_FFFF : w_cand[31:0];

    // speed while still: lose, floor at zero, cap at the gain
    assign w_loss        = w_mul_p[31:16];
    assign w_still_speed = (r_speed > 32'(w_loss)) ? r_speed - 32'(w_loss) : 32'h0;
    assign w_still_lim   = (w_still_speed > 32'(r_speed_factor)) ? 32'(r_speed_factor)
                                                                 : w_still_speed;

    // output scaling differs: delta is integer, direction is Q1.14
    assign w_shifted = r_moving ? w_mul_p[63:16] : 48'(w_mul_p[63:30]);
    assign w_q16     = 16'(w_div_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= mif_pkg::S_IDLE;
            r_launch       <= 1'b0;
            r_speed_factor <= mif_pkg::SPEED_FACTOR_RST;
            r_decel        <= mif_pkg::DECEL_RST;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_primed       <= 1'b0;
            r_dir_x        <= '0;
            r_dir_y        <= '0;
            r_speed        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_launch <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mif_pkg::CFG_SPEED_FACTOR: r_speed_factor <= i_cfg_data;
                    mif_pkg::CFG_DECELERATION: r_decel        <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            case (r_state)
                mif_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_last_x <= i_pos_x;
                        r_last_y <= i_pos_y;
                        r_primed <= 1'b1;
                        r_dt     <= i_time_step;
                        r_ax     <= w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
                        r_ay     <= w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
                        r_negx   <= w_dx[16];
                        r_negy   <= w_dy[16];
                        r_moving <= (w_dx != 17'sd0) || (w_dy != 17'sd0);
                        if (!r_primed) begin
                            // first item only records the position
                            r_res_x <= '0;
                            r_res_y <= '0;
                            r_state <= mif_pkg::S_DONE;
                        end else if ((w_dx != 17'sd0) || (w_dy != 17'sd0)) begin
                            r_state  <= mif_pkg::S_MUL_AX;
                            r_launch <= 1'b1;
                        end else begin
                            r_state  <= mif_pkg::S_MUL_LOSS;
                            r_launch <= 1'b1;
                        end
                    end
                end
                mif_pkg::S_MUL_AX: begin
                    if (w_mul_done) begin
                        r_sq     <= 33'(w_mul_p[31:0]);
                        r_state  <= mif_pkg::S_MUL_AY;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_MUL_AY: begin
                    if (w_mul_done) begin
                        r_sq     <= r_sq + 33'(w_mul_p[31:0]);
                        r_state  <= mif_pkg::S_SQRT;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_SQRT: begin
                    if (w_sq_done) begin
                        r_len    <= w_root;
                        r_state  <= mif_pkg::S_DIV_X;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_DIV_X: begin
                    if (w_div_done) begin
                        r_dir_x  <= r_negx ? 16'(-w_q16) : w_q16;
                        r_state  <= mif_pkg::S_DIV_Y;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_DIV_Y: begin
                    if (w_div_done) begin
                        r_dir_y  <= r_negy ? 16'(-w_q16) : w_q16;
                        r_state  <= mif_pkg::S_MUL_CAND;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_MUL_CAND: begin
                    if (w_mul_done) begin
                        if (w_cand_sat > r_speed) r_speed <= w_cand_sat;
                        r_state  <= mif_pkg::S_MUL_MX;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_MUL_LOSS: begin
                    if (w_mul_done) begin
                        r_speed  <= w_still_lim;
                        r_state  <= mif_pkg::S_MUL_MX;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_MUL_MX: begin
                    if (w_mul_done) begin
                        r_prod   <= w_mul_p[47:0];
                        r_state  <= mif_pkg::S_MUL_DX;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_MUL_DX: begin
                    if (w_mul_done) begin
                        r_res_x  <= mif_pkg::sat_out(r_moving ? r_negx : r_dir_x[15], w_shifted);
                        r_state  <= mif_pkg::S_MUL_MY;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_MUL_MY: begin
                    if (w_mul_done) begin
                        r_prod   <= w_mul_p[47:0];
                        r_state  <= mif_pkg::S_MUL_DY;
                        r_launch <= 1'b1;
                    end
                end
                mif_pkg::S_MUL_DY: begin
                    if (w_mul_done) begin
                        r_res_y <= mif_pkg::sat_out(r_moving ? r_negy : r_dir_y[15], w_shifted);
                        r_state <= mif_pkg::S_DONE;
                    end
                end
                mif_pkg::S_DONE: begin
                    // hand over once the output register is free or being emptied
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_move_x    <= r_res_x;
                        r_move_y    <= r_res_y;
                        r_state     <= mif_pkg::S_IDLE;
                    end
                end
                default: r_state <= mif_pkg::S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_move_x    = r_move_x;
    assign o_move_y    = r_move_y;

    // an accepted item holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input ready straight after a transfer");

    // a new result appears only as the sequencer leaves its hand-over step
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid ##1 o_out_valid) |-> $past(r_state == mif_pkg::S_DONE))
        else $error("result without hand-over");

    // the unit direction never exceeds one in Q1.14
    a_dir_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir_x >= -16'sd16384) && (r_dir_x <= 16'sd16384)
        && (r_dir_y >= -16'sd16384) && (r_dir_y <= 16'sd16384))
        else $error("direction out of range");

    // multiplier results arrive only in a multiply step
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == mif_pkg::S_MUL_AX || r_state == mif_pkg::S_MUL_AY
            || r_state == mif_pkg::S_MUL_CAND || r_state == mif_pkg::S_MUL_LOSS
            || r_state == mif_pkg::S_MUL_MX || r_state == mif_pkg::S_MUL_DX
            || r_state == mif_pkg::S_MUL_MY || r_state == mif_pkg::S_MUL_DY))
        else $error("multiplier finished outside a multiply step");
endmodule
